FILE: hdl/indexed_insert_delete_list_assert.svh
// assertion macros for the indexed insert/delete list
// used by the top level; needs clk and rst in the scope of the use
`ifndef INDEXED_INSERT_DELETE_LIST_ASSERT_SVH
`define INDEXED_INSERT_DELETE_LIST_ASSERT_SVH
`ifndef SYNTH
// checked only outside reset
`define IDL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every edge, reset included
`define IDL_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IDL_ASSERT(name, prop, msg)
`define IDL_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

FILE: hdl/idl_pkg.sv
// shared constants and types for the indexed insert/delete list
// no dependencies
`default_nettype none
package idl_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = 8;
  localparam int DATA_W   = 32;
  localparam int POS_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BOUNDS = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // broadcast to every cell of the row
  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/indexed_insert_delete_list.sv
// top level of the indexed insert/delete list: command decode, fill count,
// result registers and the row of cells; depends on idl_pkg, idl_cell and
// indexed_insert_delete_list_assert.svh
//
// usage
//   a request (cmd, index, value) is taken at a rising edge with start high
//   and busy low. busy is always low: the row of cells moves every entry
//   at the same edge, so a request may be issued on every cycle.
//   cmd: insert at index (0..count), delete at index, read at index.
//   the result (status, read_value, count) appears in the cycle after the
//   request, with done high for exactly that one cycle. the receiver
//   cannot hold results off, and none is needed: one request gives one
//   result in the next cycle, one per cycle at most.
//   throughput 1 request per cycle; each cell holds a single register stage.
//   status: ok, index out of bounds, list empty (delete), list full
//   (insert dropped). read_value is zero except on a good read.
//   count is the number of entries held after the request.
//   reset (rst, synchronous) empties the list and clears done; cell
//   contents are not cleared, only positions below count are ever read.
`default_nettype none
`include "indexed_insert_delete_list_assert.svh"
module indexed_insert_delete_list
  import idl_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output      logic                     busy,
  input  wire logic [1:0]               cmd,
  input  wire logic [IDX_W-1:0]         index,
  input  wire logic signed [DATA_W-1:0] value,
  output      logic                     done,
  output      logic [1:0]               status,
  output      logic signed [DATA_W-1:0] read_value,
  output      logic [7:0]               count
);

  // fill count and its next value
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  logic                     accept;
  logic [1:0]               status_next;
  logic signed [DATA_W-1:0] read_next;
  cell_ctl_t                ctl;

  // comparison operands at a common width
  logic [CMP_W-1:0] idx_c;
  logic [CMP_W-1:0] cnt_c;

  // the row of cells, each one entry
  logic signed [DATA_W-1:0] cell_entry [CAPACITY];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign idx_c  = CMP_W'(index);
  assign cnt_c  = CMP_W'(cnt);

  // command decode, status and count update
  always_comb begin
    status_next = ST_OK;
    read_next   = '0;
    cnt_next    = cnt;
    ctl.ins     = 1'b0;
    ctl.del     = 1'b0;
    ctl.index   = index;
    ctl.value   = value;
    if (accept) begin
      unique case (cmd)
        CMD_INSERT: begin
          if (idx_c > cnt_c) begin
            status_next = ST_BOUNDS;
          end else if (cnt_c >= CMP_W'(CAPACITY)) begin
            status_next = ST_FULL;
          end else begin
            ctl.ins  = 1'b1;
            cnt_next = cnt + CNT_W'(1);
          end
        end
        CMD_DELETE: begin
          if (cnt == '0) begin
            status_next = ST_EMPTY;
          end else if (idx_c >= cnt_c) begin
            status_next = ST_BOUNDS;
          end else begin
            ctl.del  = 1'b1;
            cnt_next = cnt - CNT_W'(1);
          end
        end
        CMD_READ: begin
          if (idx_c >= cnt_c) begin
            status_next = ST_BOUNDS;
          end else begin
            read_next = cell_entry[index[POS_W-1:0]];
          end
        end
        default: begin
          // unused command code: nothing changes
          status_next = ST_BOUNDS;
        end
      endcase
    end
  end

  // cells above the index take from the lower neighbor on insert, those at or
  // above it from the upper one on delete; the top cell sees zero above it
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] lower;
    logic signed [DATA_W-1:0] upper;
    if (g == 0) begin : g_first
      assign lower = '0;
    end else begin : g_rest
      assign lower = cell_entry[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_inner
      assign upper = cell_entry[g+1];
    end
    idl_cell u_cell (
      .clk        (clk),
      .pos        (POS_W'(g)),
      .ctl        (ctl),
      .from_lower (lower),
      .from_upper (upper),
      .entry      (cell_entry[g])
    );
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      cnt  <= cnt_next;
      done <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status     <= status_next;
      read_value <= read_next;
    end
  end

  assign count = 8'(cnt);

  `IDL_ASSERT(a_result_follows, start && !busy |=> done, "request without result")
  `IDL_ASSERT(a_count_bound, cnt <= CNT_W'(CAPACITY), "count above capacity")
  `IDL_ASSERT(a_fail_keeps_count, done && status != ST_OK |-> $stable(cnt), "count moved on a failed request")
  `IDL_ASSERT(a_ok_insert_grows, done && status == ST_OK && $past(cmd) == CMD_INSERT |-> cnt == $past(cnt) + CNT_W'(1), "insert did not grow list")
  `IDL_ASSERT(a_bad_read_zero, done && status != ST_OK |-> read_value == '0, "nonzero value on failed request")

endmodule
`default_nettype wire

FILE: hdl/idl_cell.sv
// one storage cell of the list row
// depends on idl_pkg
`default_nettype none
module idl_cell
  import idl_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic [POS_W-1:0]         pos,
  input  wire cell_ctl_t                ctl,
  input  wire logic signed [DATA_W-1:0] from_lower,
  input  wire logic signed [DATA_W-1:0] from_upper,
  output      logic signed [DATA_W-1:0] entry
);

  logic signed [DATA_W-1:0] entry_next;
  logic [IDX_W:0]           pos_ext;
  logic [IDX_W:0]           idx_ext;

  assign pos_ext = (IDX_W + 1)'(pos);
  assign idx_ext = (IDX_W + 1)'(ctl.index);

  always_comb begin
    entry_next = entry;
    if (ctl.ins) begin
      if (pos_ext > idx_ext) begin
        entry_next = from_lower;
      end else if (pos_ext == idx_ext) begin
        entry_next = ctl.value;
      end
    end else if (ctl.del) begin
      if (pos_ext >= idx_ext) begin
        entry_next = from_upper;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
`default_nettype wire

FILE: verif/tb_indexed_insert_delete_list.sv
`timescale 1ns / 100ps
// self-checking testbench for the indexed insert/delete list: random and directed requests,
// an in-bench list predictor and a per-result field compare
// depends on idl_pkg and the indexed_insert_delete_list top level
module tb_indexed_insert_delete_list;
  import idl_pkg::*;

  // the block decodes this code as "no operation", reported as out of bounds
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // one pending request plus the sender idle rate to apply while it waits
  typedef struct {
    logic [1:0]               cmd;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
    int unsigned              idle_pct;
  } list_req_t;

  // one result as the block should present it
  typedef struct {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] read_value;
    logic [7:0]               count;
  } list_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               cmd = CMD_READ;
  logic [IDX_W-1:0]         index = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     done;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] read_value;
  logic [7:0]               count;

  list_req_t    pending_reqs[$];
  list_result_t expected_results[$];
  int unsigned  mismatches = 0;

  // predicted contents of the list, kept in step with accepted requests
  logic signed [DATA_W-1:0] model_words[CAPACITY];
  int                       model_len = 0;

  // entry count as the request generator expects it when the request runs;
  // used only to steer indexes toward the interesting range
  int gen_len = 0;

  indexed_insert_delete_list u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .index      (index),
    .value      (value),
    .done       (done),
    .status     (status),
    .read_value (read_value),
    .count      (count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // single synchronous reset pulse at the start of the run
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // apply one accepted request to the predicted list and return its result
  function automatic list_result_t apply_request(logic [1:0] op, logic [IDX_W-1:0] pos,
                                                 logic signed [DATA_W-1:0] word);
    list_result_t res;
    int           idx;
    idx            = int'(pos);
    res.status     = ST_OK;
    res.read_value = '0;
    case (op)
      CMD_INSERT: begin
        // position check wins over the full check
        if (idx > model_len) begin
          res.status = ST_BOUNDS;
        end else if (model_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (int i = model_len; i > idx; i--) model_words[i] = model_words[i-1];
          model_words[idx] = word;
          model_len++;
        end
      end
      CMD_DELETE: begin
        // empty list is reported even when the index is also out of range
        if (model_len == 0) begin
          res.status = ST_EMPTY;
        end else if (idx >= model_len) begin
          res.status = ST_BOUNDS;
        end else begin
          for (int i = idx; i + 1 < model_len; i++) model_words[i] = model_words[i+1];
          model_len--;
        end
      end
      CMD_READ: begin
        if (idx >= model_len) res.status = ST_BOUNDS;
        else res.read_value = model_words[idx];
      end
      default: res.status = ST_BOUNDS;
    endcase
    res.count = model_len[7:0];
    return res;
  endfunction

  // one line per mismatch, counted for the final verdict
  task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // queue a request and track the count it leaves behind
  task automatic queue_request(logic [1:0] op, int idx, logic signed [DATA_W-1:0] word,
                               int unsigned pct);
    list_req_t r;
    r.cmd      = op;
    r.index    = idx[IDX_W-1:0];
    r.value    = word;
    r.idle_pct = pct;
    pending_reqs.push_back(r);
    if (op == CMD_INSERT && idx <= gen_len && gen_len < CAPACITY) gen_len++;
    else if (op == CMD_DELETE && idx < gen_len) gen_len--;
  endtask

  // driver: a request stays on the ports until taken; between requests the
  // sender may go idle at the rate carried by the next request
  always @(posedge clk) begin
    list_req_t next_req;
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= pending_reqs[0].idle_pct) begin
        next_req = pending_reqs.pop_front();
        start    <= 1'b1;
        cmd      <= next_req.cmd;
        index    <= next_req.index;
        value    <= next_req.value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check the strobed result against the oldest prediction, then
  // predict for any request taken at this edge
  always @(posedge clk) begin
    list_result_t want;
    if (!rst) begin
      if (done) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result strobe", {30'd0, status}, '0);
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status) report_mismatch("status", status, want.status);
          if (read_value !== want.read_value)
            report_mismatch("read_value", read_value, want.read_value);
          if (count !== want.count) report_mismatch("count", count, want.count);
        end
      end
      if (start && !busy) expected_results.push_back(apply_request(cmd, index, value));
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned pct;
    int unsigned roll;
    int unsigned mode;
    int          idx;
    logic [1:0]  op;

    // directed: empty-list corner cases first
    queue_request(CMD_READ,   0,   32'sd0, 0);
    queue_request(CMD_DELETE, 0,   32'sd0, 0);
    queue_request(CMD_DELETE, 255, 32'sd0, 0);   // empty beats out of range
    queue_request(CMD_READ,   255, 32'sd0, 0);
    queue_request(CMD_INSERT, 1,   32'sd7, 0);   // insert past the end
    queue_request(CMD_UNUSED, 0,   32'sd0, 0);
    // build a short list with extreme values at front, end and middle
    queue_request(CMD_INSERT, 0, 32'sh80000000, 0);
    queue_request(CMD_INSERT, 1, 32'sh7fffffff, 0);
    queue_request(CMD_INSERT, 0, -32'sd1, 0);
    queue_request(CMD_INSERT, 3, 32'sd0, 0);
    queue_request(CMD_INSERT, 2, 32'sh5a5a5a5a, 0);
    queue_request(CMD_INSERT, 6, 32'sh12345678, 0); // one past the append slot
    queue_request(CMD_READ, 0, 32'sd0, 0);
    queue_request(CMD_READ, 4, 32'sd0, 0);
    queue_request(CMD_READ, 5, 32'sd0, 0);
    queue_request(CMD_READ, 2, -32'sd1, 0);
    // removal from middle, tail and head, plus out-of-range delete
    queue_request(CMD_DELETE, 5, 32'sd0, 0);
    queue_request(CMD_DELETE, 2, 32'sd0, 0);
    queue_request(CMD_DELETE, 3, 32'sd0, 0);
    queue_request(CMD_DELETE, 0, 32'sd0, 0);
    queue_request(CMD_READ, 1, 32'sd0, 0);
    queue_request(CMD_UNUSED, 255, -32'sd1, 0);
    queue_request(CMD_INSERT, 255, -32'sd1, 0);

    // random: bursts that fill toward full, drain toward empty, or mix,
    // with idle phases of 0, 53, 0 and 23 percent
    for (int n = 0; n < 600; n++) begin
      case (n / 150)
        1:       pct = 53;
        3:       pct = 23;
        default: pct = 0;
      endcase
      mode = (n / 40) % 4;                 // 0 fill, 1 mix, 2 drain, 3 mix
      roll = $urandom_range(99);
      if (roll < 2) begin
        op = CMD_UNUSED;
      end else if (mode == 0) begin
        op = (roll < 75) ? CMD_INSERT : (roll < 87) ? CMD_DELETE : CMD_READ;
      end else if (mode == 2) begin
        op = (roll < 70) ? CMD_DELETE : (roll < 82) ? CMD_INSERT : CMD_READ;
      end else begin
        op = (roll < 38) ? CMD_INSERT : (roll < 68) ? CMD_DELETE : CMD_READ;
      end
      // mostly legal positions, some just past the end, a few anywhere
      roll = $urandom_range(99);
      if (roll < 85) begin
        if (op == CMD_INSERT) idx = $urandom_range(gen_len, 0);
        else idx = (gen_len == 0) ? 0 : $urandom_range(gen_len - 1, 0);
      end else if (roll < 95) begin
        idx = gen_len + $urandom_range(1, 0);
      end else begin
        idx = $urandom_range(255, 0);
      end
      queue_request(op, idx, $urandom(), pct);
    end

    // drain: every request taken and every predicted result seen
    while (pending_reqs.size() != 0 || start || expected_results.size() != 0)
      @(negedge clk);
    // the extra wait catches any stray strobe
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("indexed_insert_delete_list verification clean");
    end else begin
      $display("indexed_insert_delete_list verification failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #1000000;
    $display("indexed_insert_delete_list verification failed");
    $finish;
  end

endmodule
